[hw/rtl/ulcm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulcm_pkg: shared types and constants for the UART line command matcher
// Holds the character codes, the command texts, the result descriptor
// passed from the line store to the output sequencer, and the match function.
// ----------------------------------------------------------------------------
package ulcm_pkg;

	// Default sizes of the line store.
	localparam int LINE_MAX_DEF   = 512;
	localparam int PREFIX_LEN_DEF = 9;

	// Character codes.
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;

	// Command table.
	localparam int         NUM_CMDS = 4;
	localparam int         CMD_MAX  = 9;
	localparam logic [2:0] NO_MATCH = 3'd4;

	// "LED1 on\n", "LED1 off\n", "LED2 on\n", "LED2 off\n", padded with zero.
	localparam logic [7:0] CMD_TEXT [NUM_CMDS][CMD_MAX] = '{
		'{8'h4C, 8'h45, 8'h44, 8'h31, 8'h20, 8'h6F, 8'h6E, 8'h0A, 8'h00},
		'{8'h4C, 8'h45, 8'h44, 8'h31, 8'h20, 8'h6F, 8'h66, 8'h66, 8'h0A},
		'{8'h4C, 8'h45, 8'h44, 8'h32, 8'h20, 8'h6F, 8'h6E, 8'h0A, 8'h00},
		'{8'h4C, 8'h45, 8'h44, 8'h32, 8'h20, 8'h6F, 8'h66, 8'h66, 8'h0A}
	};
	localparam logic [3:0] CMD_LEN [NUM_CMDS] = '{4'd8, 4'd9, 4'd8, 4'd9};

	// Kind of result sequence caused by one input byte.
	localparam logic [1:0] OP_NONE  = 2'd0; // line discarded, nothing to send
	localparam logic [1:0] OP_ECHO  = 2'd1; // echo the byte itself
	localparam logic [1:0] OP_ERASE = 2'd2; // backspace, space, backspace
	localparam logic [1:0] OP_LINE  = 2'd3; // newline echo, then match result

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] rx;
		logic [2:0] code;
	} ulcm_res_t;

	typedef logic [CMD_MAX-1:0][7:0] line_head_t;

	// Index of the first command equal to the line head, or NO_MATCH.
	function automatic logic [2:0] match_line(line_head_t head);
		logic [2:0] code;
		logic       same;
		code = NO_MATCH;
		// Walk backwards so that the lowest matching index wins.
		for (int c = NUM_CMDS - 1; c >= 0; c--) begin
			same = 1'b1;
			for (int i = 0; i < CMD_MAX; i++) begin
				if (i < int'(CMD_LEN[c]) && head[i] != CMD_TEXT[c][i]) begin
					same = 1'b0;
				end
			end
			if (same) begin
				code = 3'(c);
			end
		end
		return code;
	endfunction

endpackage

[hw/rtl/ulcm_line.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulcm_line: edited line store and command compare
// Keeps the stored prefix of the line and its position count, applies one
// received byte per transfer and describes the results that it causes.
// ----------------------------------------------------------------------------
module ulcm_line #(
	parameter int LINE_MAX   = ulcm_pkg::LINE_MAX_DEF,
	parameter int PREFIX_LEN = ulcm_pkg::PREFIX_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          rx_byte,
	output ulcm_pkg::ulcm_res_t res
);

	localparam int POS_W = $clog2(LINE_MAX + 1);

	logic [7:0]       prefix_q [PREFIX_LEN];
	logic [POS_W-1:0] pos_q;

	logic [7:0]           prefix_d [PREFIX_LEN];
	logic [POS_W-1:0]     pos_d;
	logic [7:0]           line_new [PREFIX_LEN];
	ulcm_pkg::line_head_t head;
	logic                 is_bs;
	logic                 is_nl;
	logic                 empty;
	logic                 full;

	assign is_bs = (rx_byte == ulcm_pkg::CH_BS);
	assign is_nl = (rx_byte == ulcm_pkg::CH_NL);
	assign empty = (pos_q == '0);
	assign full  = (pos_q == POS_W'(LINE_MAX));

	// Line with the received byte written at the current position.
	always_comb begin
		for (int i = 0; i < PREFIX_LEN; i++) begin
			line_new[i] = (pos_q == POS_W'(i)) ? rx_byte : prefix_q[i];
		end
		for (int i = 0; i < ulcm_pkg::CMD_MAX; i++) begin
			head[i] = line_new[i];
		end
	end

	// Next state and result description.
	always_comb begin
		prefix_d = prefix_q;
		pos_d    = pos_q;
		res.op   = ulcm_pkg::OP_NONE;
		res.rx   = rx_byte;
		res.code = ulcm_pkg::match_line(head);
		priority if (is_bs && !empty) begin
			// Erase the last byte; clear it if it lies in the stored prefix.
			pos_d = pos_q - POS_W'(1);
			for (int i = 0; i < PREFIX_LEN; i++) begin
				if (pos_d == POS_W'(i)) begin
					prefix_d[i] = 8'h00;
				end
			end
			res.op = ulcm_pkg::OP_ERASE;
		end else if (full) begin
			// Overlong line: drop the byte and start afresh.
			for (int i = 0; i < PREFIX_LEN; i++) begin
				prefix_d[i] = 8'h00;
			end
			pos_d = '0;
		end else if (is_nl) begin
			for (int i = 0; i < PREFIX_LEN; i++) begin
				prefix_d[i] = 8'h00;
			end
			pos_d  = '0;
			res.op = ulcm_pkg::OP_LINE;
		end else begin
			prefix_d = line_new;
			pos_d    = pos_q + POS_W'(1);
			res.op   = ulcm_pkg::OP_ECHO;
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int i = 0; i < PREFIX_LEN; i++) begin
				prefix_q[i] <= 8'h00;
			end
		end else if (take) begin
			pos_q    <= pos_d;
			prefix_q <= prefix_d;
		end
	end

	// The position never runs past the saturation point.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(LINE_MAX))
		else $error("line position beyond its limit");

	// A newline always leaves an empty line behind.
	a_nl_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && res.op == ulcm_pkg::OP_LINE |=> pos_q == '0)
		else $error("line not cleared after newline");

	// A discarded line leaves nothing stored.
	a_full_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && full && !is_bs |=> pos_q == '0 && prefix_q[0] == 8'h00)
		else $error("overlong line not discarded");

endmodule

[hw/rtl/uart_line_command_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_line_command_matcher: UART line editor with command recognition
// Edits a received line, echoes the bytes and reports which of four fixed
// LED commands a completed line matches.
// ----------------------------------------------------------------------------
// A byte's first result is offered in the cycle after its transfer. Ordinary bytes
// are taken at one byte per cycle unless stalled; a newline or an erasing backspace
// holds the input until all its results have left. The single result register
// sends one result per cycle unless stalled and takes the next byte with the last.
// Reset: arst_n clears the stored line, the position count and the result register.
module uart_line_command_matcher #(
	parameter int LINE_MAX   = ulcm_pkg::LINE_MAX_DEF,
	parameter int PREFIX_LEN = ulcm_pkg::PREFIX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [7:0] echo_byte,
	output logic [2:0] match_code,
	output logic       last
);

	ulcm_pkg::ulcm_res_t res;
	ulcm_pkg::ulcm_res_t res_q;
	logic                valid_q;
	logic [1:0]          idx_q;
	logic                in_take;
	logic                out_take;

	ulcm_line #(
		.LINE_MAX   (LINE_MAX),
		.PREFIX_LEN (PREFIX_LEN)
	) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (in_take),
		.rx_byte (rx_byte),
		.res     (res)
	);

	// Handshakes: a new byte enters when no result is pending or as the last one leaves.
	assign out_valid = valid_q;
	assign out_take  = valid_q && !out_stall;
	assign in_stall  = valid_q && !(out_take && last);
	assign in_take   = in_valid && !in_stall;

	// Fields of the result currently offered.
	always_comb begin
		kind       = 1'b0;
		echo_byte  = 8'h00;
		match_code = 3'd0;
		last       = 1'b0;
		unique case (res_q.op)
			ulcm_pkg::OP_ECHO: begin
				echo_byte = res_q.rx;
				last      = 1'b1;
			end
			ulcm_pkg::OP_ERASE: begin
				echo_byte = (idx_q == 2'd1) ? ulcm_pkg::CH_SP : ulcm_pkg::CH_BS;
				last      = (idx_q == 2'd2);
			end
			ulcm_pkg::OP_LINE: begin
				kind       = (idx_q == 2'd1);
				echo_byte  = (idx_q == 2'd1) ? 8'h00 : ulcm_pkg::CH_NL;
				match_code = (idx_q == 2'd1) ? res_q.code : 3'd0;
				last       = (idx_q == 2'd1);
			end
			default: begin
			end
		endcase
	end

	// Result register and sequence counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			idx_q      <= 2'd0;
			res_q.op   <= ulcm_pkg::OP_NONE;
			res_q.rx   <= 8'h00;
			res_q.code <= 3'd0;
		end else if (in_take) begin
			valid_q <= (res.op != ulcm_pkg::OP_NONE);
			idx_q   <= 2'd0;
			res_q   <= res;
		end else if (out_take) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// A byte is only taken when no result is left behind.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |-> !valid_q || (out_take && last))
		else $error("byte taken while results still pending");

	// A match result always closes its sequence.
	a_kind_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && kind |-> last && match_code <= ulcm_pkg::NO_MATCH)
		else $error("match result not last or out of range");

	// The sequence counter stays within the length of its sequence.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> res_q.op != ulcm_pkg::OP_NONE && idx_q != 2'd3
			&& (res_q.op != ulcm_pkg::OP_ECHO || idx_q == 2'd0))
		else $error("result sequence counter out of range");

	// A non-final result is followed by another of the same sequence.
	a_seq_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && !last |=> valid_q && $stable(res_q.op))
		else $error("result sequence broken off");

endmodule
